// ===== hw/rtl/hhs_pkg.sv =====
// Shared phase codes, tables and helper functions for the H.264 header scanner.
package hhs_pkg;

	typedef enum logic [5:0] {
		PH_SCAN = 6'd0, PH_ALIGN = 6'd1, PH_EXT = 6'd2, PH_PROFILE = 6'd3,
		PH_CONSTRAINT = 6'd4, PH_LEVEL = 6'd5, PH_SPS_ID = 6'd6, PH_CHROMA = 6'd7,
		PH_SEP_PLANE = 6'd8, PH_DEPTH_LUMA = 6'd9, PH_DEPTH_CHROMA = 6'd10,
		PH_BYPASS = 6'd11, PH_MATRIX = 6'd12, PH_LISTS = 6'd13, PH_LOG2_FN = 6'd14,
		PH_POC_TYPE = 6'd15, PH_POC_LSB = 6'd16, PH_DELTA_ZERO = 6'd17,
		PH_NONREF = 6'd18, PH_TOPBOT = 6'd19, PH_CYCLE_LEN = 6'd20,
		PH_REF_OFFSET = 6'd21, PH_MAX_REF = 6'd22, PH_GAPS = 6'd23, PH_WIDTH = 6'd24,
		PH_HEIGHT = 6'd25, PH_FRAME_MBS = 6'd26, PH_MBAFF = 6'd27, PH_DIRECT8 = 6'd28,
		PH_CROP_FLAG = 6'd29, PH_CROP_L = 6'd30, PH_CROP_R = 6'd31, PH_CROP_T = 6'd32,
		PH_CROP_B = 6'd33, PH_VUI = 6'd34, PH_FIRST_MB = 6'd35,
		PH_SLICE_TYPE = 6'd36, PH_PPS = 6'd37, PH_PLANE = 6'd38, PH_FRAME_NUM = 6'd39
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_BITS = 3'b010,
		ST_OUT  = 3'b100
	} ctl_state_t;

	localparam logic [4:0] NAL_SPS = 5'd7;
	localparam logic [4:0] NAL_NONIDR = 5'd1;
	localparam logic [4:0] NAL_PART_A = 5'd2;
	localparam logic [4:0] NAL_IDR = 5'd5;
	localparam logic [4:0] NAL_PREFIX = 5'd14;
	localparam logic [4:0] NAL_EXT = 5'd20;

	typedef struct packed {
		logic        kind;
		logic [15:0] width;
		logic [15:0] height;
		logic [15:0] number;
		logic [3:0]  slice;
		logic [31:0] position;
	} event_t;

	typedef struct packed {
		logic        fin;
		logic [31:0] value;
	} elem_t;

	function automatic logic phase_is_golomb(input phase_t ph);
		logic g;
		unique case (ph)
			PH_SPS_ID, PH_CHROMA, PH_DEPTH_LUMA, PH_DEPTH_CHROMA, PH_LOG2_FN,
			PH_POC_TYPE, PH_POC_LSB, PH_NONREF, PH_TOPBOT, PH_CYCLE_LEN,
			PH_REF_OFFSET, PH_MAX_REF, PH_WIDTH, PH_HEIGHT, PH_CROP_L, PH_CROP_R,
			PH_CROP_T, PH_CROP_B, PH_FIRST_MB, PH_SLICE_TYPE, PH_PPS: g = 1'b1;
			default: g = 1'b0;
		endcase
		return g;
	endfunction

	function automatic logic [4:0] phase_length(input phase_t ph, input logic [1:0] chroma,
		input logic [3:0] fnb);
		logic [4:0] n;
		unique case (ph)
			PH_EXT: n = 5'd24;
			PH_PROFILE, PH_CONSTRAINT, PH_LEVEL: n = 5'd8;
			PH_LISTS: n = (chroma == 2'd3) ? 5'd12 : 5'd8;
			PH_PLANE: n = 5'd2;
			PH_FRAME_NUM: n = {1'b0, fnb} + 5'd4;
			default: n = 5'd1;
		endcase
		return n;
	endfunction

	function automatic logic high_profile(input logic [7:0] p);
		return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 ||
			p == 8'd44 || p == 8'd83 || p == 8'd86 || p == 8'd118 || p == 8'd128;
	endfunction

	function automatic logic [15:0] pixels16(input logic [31:0] m1);
		logic [32:0] s;
		s = {1'b0, m1} + 33'd1;
		return (s[32:12] != 21'd0) ? 16'hffff : {s[11:0], 4'd0};
	endfunction

endpackage

// ===== hw/rtl/hhs_golomb.sv =====
// Bit-serial fixed-length and exp-Golomb element reader.
module hhs_golomb import hhs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clear,
	input  logic        step,
	input  logic        bit_in,
	input  logic        golomb,
	input  logic [4:0]  len,
	output elem_t       elem
);
	logic        counting_q;
	logic [4:0]  zeros_q;
	logic [31:0] acc_q;
	logic [4:0]  nacc_q;
	logic [31:0] acc_next;
	logic [4:0]  nacc_next;
	logic [31:0] base;

	assign acc_next = {acc_q[30:0], bit_in};
	assign nacc_next = nacc_q + 5'd1;
	assign base = (32'd1 << zeros_q) - 32'd1;

	always_comb begin
		elem.fin = 1'b0;
		elem.value = acc_next;
		if (!golomb) begin
			elem.fin = nacc_next >= len;
		end else if (counting_q) begin
			elem.fin = bit_in && zeros_q == 5'd0;
			elem.value = 32'd0;
		end else begin
			elem.fin = nacc_next >= zeros_q;
			elem.value = base + acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counting_q <= 1'b1;
			zeros_q <= '0;
			acc_q <= '0;
			nacc_q <= '0;
		end else if (clear || (step && elem.fin)) begin
			counting_q <= 1'b1;
			zeros_q <= '0;
			acc_q <= '0;
			nacc_q <= '0;
		end else if (step) begin
			if (golomb && counting_q) begin
				if (bit_in) counting_q <= 1'b0;
				else if (zeros_q != 5'd31) zeros_q <= zeros_q + 5'd1;
			end else begin
				acc_q <= acc_next;
				nacc_q <= nacc_next;
			end
		end
	end
endmodule

// ===== hw/rtl/h264_header_scanner.sv =====
// Top level of the H.264 Annex B header scanner.
// Usage: feed the Annex B stream on data_byte/valid_in; stall_in pushes back.
// Each accepted transaction is one stream byte. Bytes in start-code scan and
// dropped emulation-prevention bytes are taken without leaving the idle state
// and may follow back to back. A header byte is loaded into the shift register
// and then shifted through the element reader one bit per cycle, until all
// eight bits are read or the header ends inside the byte.
// A byte that yields a result (SPS frame size or new-frame slice) then passes
// through a hand-off state that loads it into the output register, which
// holds it with valid_out until stall_out is low.
// While a result waits, the next bytes are accepted and decoded; a byte that
// yields a further result holds in the hand-off state, with stall_in high,
// until the output register is taken.
// Reset clears all parse state: scanning resumes at start-code search,
// stream offset zero, stored frame number zero.
module h264_header_scanner import hhs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_in,
	output logic        stall_in,
	input  logic [7:0]  data_byte,
	output logic        valid_out,
	input  logic        stall_out,
	output logic        event_kind,
	output logic [15:0] frame_width,
	output logic [15:0] frame_height,
	output logic [15:0] frame_number,
	output logic [3:0]  slice_kind,
	output logic [31:0] slice_position
);
	ctl_state_t  state_q;
	phase_t      phase_q;
	logic [2:0]  pzc_q;
	logic [1:0]  esc_q;
	logic [31:0] seen_q;
	logic [31:0] start_q;
	logic [7:0]  shift_q;
	logic [2:0]  bitcnt_q;
	logic        emitted_q;
	logic [7:0]  profile_q;
	logic [1:0]  chroma_q;
	logic        sep_q;
	logic [3:0]  fnb_q;
	logic [7:0]  refleft_q;
	logic [31:0] width_q;
	logic [15:0] lastfn_q;
	logic [3:0]  lastsk_q;
	event_t      pend_q;
	event_t      ev_q;
	logic        ovalid_q;
	logic        out_load;
	event_t      ev_new;
	logic        ev_fire;
	logic        accept;
	logic        rd_clear;
	logic        step;
	elem_t       elem;
	phase_t      ph_next;
	phase_t      eff_ph;
	logic [4:0]  unit;
	logic [15:0] fn16;

	assign accept = valid_in && !stall_in;
	assign stall_in = (state_q != ST_IDLE);
	assign step = (state_q == ST_BITS);
	assign unit = data_byte[4:0];
	assign fn16 = elem.value[15:0];
	assign out_load = (state_q == ST_OUT) && (!ovalid_q || !stall_out);

	hhs_golomb u_rd (
		.clk(clk), .arst_n(arst_n), .clear(rd_clear), .step(step),
		.bit_in(shift_q[7]), .golomb(phase_is_golomb(phase_q)),
		.len(phase_length(phase_q, chroma_q, fnb_q)), .elem(elem)
	);

	always_comb begin
		ph_next = phase_q;
		ev_fire = 1'b0;
		ev_new = '0;
		unique case (phase_q)
			PH_EXT: ph_next = PH_SCAN;
			PH_PROFILE: ph_next = PH_CONSTRAINT;
			PH_CONSTRAINT: ph_next = PH_LEVEL;
			PH_LEVEL: ph_next = PH_SPS_ID;
			PH_SPS_ID: ph_next = high_profile(profile_q) ? PH_CHROMA : PH_LOG2_FN;
			PH_CHROMA: ph_next = (elem.value > 32'd2) ? PH_SEP_PLANE : PH_DEPTH_LUMA;
			PH_SEP_PLANE: ph_next = PH_DEPTH_LUMA;
			PH_DEPTH_LUMA: ph_next = PH_DEPTH_CHROMA;
			PH_DEPTH_CHROMA: ph_next = PH_BYPASS;
			PH_BYPASS: ph_next = PH_MATRIX;
			PH_MATRIX: ph_next = (elem.value != 0) ? PH_LISTS : PH_LOG2_FN;
			PH_LISTS: ph_next = PH_LOG2_FN;
			PH_LOG2_FN: ph_next = PH_POC_TYPE;
			PH_POC_TYPE: ph_next = (elem.value == 0) ? PH_POC_LSB :
				(elem.value == 32'd1) ? PH_DELTA_ZERO : PH_MAX_REF;
			PH_POC_LSB: ph_next = PH_MAX_REF;
			PH_DELTA_ZERO: ph_next = PH_NONREF;
			PH_NONREF: ph_next = PH_TOPBOT;
			PH_TOPBOT: ph_next = PH_CYCLE_LEN;
			PH_CYCLE_LEN: ph_next = (elem.value == 0) ? PH_MAX_REF : PH_REF_OFFSET;
			PH_REF_OFFSET: ph_next = (refleft_q <= 8'd1) ? PH_MAX_REF : PH_REF_OFFSET;
			PH_MAX_REF: ph_next = PH_GAPS;
			PH_GAPS: ph_next = PH_WIDTH;
			PH_WIDTH: ph_next = PH_HEIGHT;
			PH_HEIGHT: begin
				ph_next = PH_FRAME_MBS;
				ev_fire = !emitted_q;
				ev_new.kind = 1'b0;
				ev_new.width = pixels16(width_q);
				ev_new.height = pixels16(elem.value);
			end
			PH_FRAME_MBS: ph_next = (elem.value != 0) ? PH_DIRECT8 : PH_MBAFF;
			PH_MBAFF: ph_next = PH_DIRECT8;
			PH_DIRECT8: ph_next = PH_CROP_FLAG;
			PH_CROP_FLAG: ph_next = (elem.value != 0) ? PH_CROP_L : PH_VUI;
			PH_CROP_L: ph_next = PH_CROP_R;
			PH_CROP_R: ph_next = PH_CROP_T;
			PH_CROP_T: ph_next = PH_CROP_B;
			PH_CROP_B: ph_next = PH_VUI;
			PH_VUI: ph_next = PH_ALIGN;
			PH_FIRST_MB: ph_next = PH_SLICE_TYPE;
			PH_SLICE_TYPE: ph_next = PH_PPS;
			PH_PPS: ph_next = sep_q ? PH_PLANE : PH_FRAME_NUM;
			PH_PLANE: ph_next = PH_FRAME_NUM;
			PH_FRAME_NUM: begin
				ph_next = PH_ALIGN;
				ev_fire = (fn16 != lastfn_q) && !emitted_q;
				ev_new.kind = 1'b1;
				ev_new.number = fn16;
				ev_new.slice = lastsk_q;
				ev_new.position = start_q;
			end
			default: ph_next = PH_SCAN;
		endcase
	end

	always_comb begin
		eff_ph = phase_q;
		if (phase_q == PH_ALIGN) eff_ph = PH_SCAN;
		rd_clear = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_SCAN;
			pzc_q <= '0;
			esc_q <= '0;
			seen_q <= '0;
			start_q <= '0;
			shift_q <= '0;
			bitcnt_q <= '0;
			emitted_q <= 1'b0;
			profile_q <= '0;
			chroma_q <= '0;
			sep_q <= 1'b0;
			fnb_q <= '0;
			refleft_q <= '0;
			width_q <= '0;
			lastfn_q <= '0;
			lastsk_q <= '0;
			pend_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) begin
					seen_q <= seen_q + 32'd1;
					shift_q <= data_byte;
					bitcnt_q <= '0;
					emitted_q <= 1'b0;
					if (phase_q != PH_SCAN && esc_q == 2'd2) begin
						esc_q <= '0;
						if (data_byte == 8'h03) begin
						end else if (eff_ph != PH_SCAN) begin
							phase_q <= eff_ph;
							state_q <= ST_BITS;
						end else begin
							phase_q <= PH_SCAN;
							if (pzc_q < 3'd3) pzc_q <= (data_byte == 0) ? pzc_q + 3'd1 : 3'd0;
						end
					end else begin
						if (phase_q != PH_SCAN)
							esc_q <= (data_byte == 0) ? esc_q + 2'd1 : 2'd0;
						if (eff_ph != PH_SCAN) begin
							state_q <= ST_BITS;
						end else begin
							phase_q <= PH_SCAN;
							if (pzc_q < 3'd3) begin
								pzc_q <= (data_byte == 0) ? pzc_q + 3'd1 : 3'd0;
							end else if (pzc_q == 3'd3) begin
								if (data_byte == 8'd1) begin
									start_q <= seen_q - 32'd3;
									pzc_q <= 3'd4;
								end else if (data_byte != 0) begin
									pzc_q <= 3'd0;
								end
							end else begin
								pzc_q <= '0;
								if (unit == NAL_SPS) phase_q <= PH_PROFILE;
								else if (unit == NAL_NONIDR || unit == NAL_PART_A ||
									unit == NAL_IDR) phase_q <= PH_FIRST_MB;
								else if (unit == NAL_PREFIX || unit == NAL_EXT)
									phase_q <= PH_EXT;
							end
						end
					end
				end
				ST_BITS: begin
					shift_q <= {shift_q[6:0], 1'b0};
					bitcnt_q <= bitcnt_q + 3'd1;
					if (elem.fin) begin
						if (ev_fire) begin
							pend_q <= ev_new;
							emitted_q <= 1'b1;
						end
						unique case (phase_q)
							PH_PROFILE: begin
								profile_q <= elem.value[7:0];
								sep_q <= 1'b0;
							end
							PH_CHROMA: chroma_q <= (elem.value > 32'd3) ? 2'd3 : elem.value[1:0];
							PH_SEP_PLANE: sep_q <= elem.value[0];
							PH_LOG2_FN: fnb_q <= (elem.value > 32'd15) ? 4'd15 : elem.value[3:0];
							PH_CYCLE_LEN: refleft_q <= (elem.value > 32'd255) ? 8'd255 :
								elem.value[7:0];
							PH_REF_OFFSET: refleft_q <= (refleft_q <= 8'd1) ? 8'd0 :
								refleft_q - 8'd1;
							PH_WIDTH: width_q <= elem.value;
							PH_SLICE_TYPE: lastsk_q <= (elem.value > 32'd15) ? 4'd15 :
								elem.value[3:0];
							PH_FRAME_NUM: if (fn16 != lastfn_q) lastfn_q <= fn16;
							default: ;
						endcase
						if (ph_next == PH_ALIGN && bitcnt_q != 3'd7) phase_q <= PH_SCAN;
						else phase_q <= ph_next;
						if (ph_next == PH_SCAN || ph_next == PH_ALIGN || bitcnt_q == 3'd7)
							state_q <= (ev_fire || emitted_q) ? ST_OUT : ST_IDLE;
					end else if (bitcnt_q == 3'd7) begin
						state_q <= emitted_q ? ST_OUT : ST_IDLE;
					end
				end
				ST_OUT: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			ev_q <= '0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
			ev_q <= pend_q;
		end else if (!stall_out) begin
			ovalid_q <= 1'b0;
		end
	end

	assign valid_out = ovalid_q;
	assign event_kind = ev_q.kind;
	assign frame_width = ev_q.width;
	assign frame_height = ev_q.height;
	assign frame_number = ev_q.number;
	assign slice_kind = ev_q.slice;
	assign slice_position = ev_q.position;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && stall_out |=> valid_out && $stable(slice_position))
		else $error("result dropped under stall");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BITS |-> stall_in)
		else $error("input taken while shifting");
	a_pzc: assert property (@(posedge clk) disable iff (!arst_n)
		pzc_q <= 3'd4)
		else $error("prefix count out of range");
endmodule
